// File: rtl/p2v_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// p2v_pkg: shared types and constants
// Payload structs, register indexes, palette table and the distance
// helper used by the pixel to packed video-memory byte converter.
// ----------------------------------------------------------------------------
package p2v_pkg;

	// one RGB pixel
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} p2v_pixel_t;

	// one packed output byte
	typedef struct packed {
		logic [7:0] vram_byte;
		logic       row_done;
	} p2v_byte_t;

	// configuration write request
	typedef struct packed {
		logic [1:0] index;
		logic [8:0] wdata;
	} p2v_cfg_wr_t;

	// configuration register contents
	typedef struct packed {
		logic       pixel_mode;
		logic       palette_select;
		logic [8:0] row_width;
	} p2v_cfg_t;

	// classified work item, front to back
	typedef struct packed {
		logic       mode;    // 0 palette, 1 mono
		logic       pal;     // palette select
		logic       place;   // item puts a code into the byte
		logic       emit;    // byte goes out after this item
		logic       last;    // last pixel of the row
		logic [2:0] slot;    // slot within the byte
		p2v_pixel_t pix;     // averaged pair or raw pixel
	} p2v_item_t;

	// register indexes
	localparam logic [1:0] REG_PIXEL_MODE     = 2'd0;
	localparam logic [1:0] REG_PALETTE_SELECT = 2'd1;
	localparam logic [1:0] REG_ROW_WIDTH      = 2'd2;

	localparam logic [8:0] ROW_WIDTH_RESET = 9'd256;

	// pixel modes
	localparam logic MODE_PALETTE = 1'b0;
	localparam logic MODE_MONO    = 1'b1;

	// luma weights; luma/1000 > 127 is the same as sum >= 128 * 1000
	localparam int                DIST_W      = 18;
	localparam logic [DIST_W-1:0] LUMA_R      = 18'd299;
	localparam logic [DIST_W-1:0] LUMA_G      = 18'd587;
	localparam logic [DIST_W-1:0] LUMA_B      = 18'd114;
	localparam logic [DIST_W-1:0] LUMA_THRESH = 18'd128000;

	localparam int QUEUE_DEPTH = 4;

	// palette colors [select][index][r,g,b]
	localparam logic [7:0] PAL_TABLE [2][4][3] = '{
		'{ '{8'd0,   8'd255, 8'd0},   '{8'd255, 8'd255, 8'd0},
		   '{8'd0,   8'd0,   8'd255}, '{8'd255, 8'd0,   8'd0} },
		'{ '{8'd255, 8'd255, 8'd255}, '{8'd0,   8'd255, 8'd255},
		   '{8'd255, 8'd0,   8'd255}, '{8'd255, 8'd128, 8'd0} }
	};

	// squared RGB distance between a pixel and a palette color
	function automatic logic [DIST_W-1:0] p2v_sqdist(input p2v_pixel_t p,
			input logic [7:0] pr, input logic [7:0] pg, input logic [7:0] pb);
		logic [7:0]  dr, dg, db;
		logic [15:0] sr, sg, sb;
		dr = (p.red   > pr) ? (p.red   - pr) : (pr - p.red);
		dg = (p.green > pg) ? (p.green - pg) : (pg - p.green);
		db = (p.blue  > pb) ? (p.blue  - pb) : (pb - p.blue);
		sr = dr * dr;
		sg = dg * dg;
		sb = db * db;
		return DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
	endfunction

endpackage
`default_nettype wire

// File: rtl/p2v_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// p2v_stream_if: valid/ready channel
// Carries one request of the given payload type per accepted handshake.
// ----------------------------------------------------------------------------
interface p2v_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/p2v_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// p2v_front: pixel intake and classification
// Tracks row position, slot count and the held pixel of a pair, averages
// pairs in palette mode and tags each pixel with its slot and byte events.
// ----------------------------------------------------------------------------
module p2v_front #(
	parameter int MAX_ROW_WIDTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  p2v_pkg::p2v_cfg_t cfg_state,
	p2v_stream_if.sink        pixel_in,
	p2v_stream_if.source      item_out
);
	import p2v_pkg::*;

	localparam int COLW = $clog2(MAX_ROW_WIDTH);
	localparam int CW   = $clog2(MAX_ROW_WIDTH + 1);
	localparam int LW   = (CW > 9) ? CW : 9;

	logic [COLW-1:0] col_q;
	logic [2:0]      slot_q;
	p2v_pixel_t      held_q;

	logic [LW-1:0] rw_ext, width, col_next_ext;
	logic          accept, last, even, place, full, emit;
	logic [2:0]    slot_cur, slot_new;
	logic [8:0]    sum_r, sum_g, sum_b;
	p2v_pixel_t    pix;
	p2v_item_t     item;

	assign pixel_in.ready = item_out.ready;
	assign item_out.valid = pixel_in.valid;
	assign accept         = pixel_in.valid && pixel_in.ready;

	// effective width: zero acts as one, clamp at the maximum
	always_comb begin
		rw_ext = LW'(cfg_state.row_width);
		if (cfg_state.row_width == 9'd0) begin
			width = LW'(1);
		end else if (rw_ext > LW'(MAX_ROW_WIDTH)) begin
			width = LW'(MAX_ROW_WIDTH);
		end else begin
			width = rw_ext;
		end
		col_next_ext = LW'(col_q) + LW'(1);
		last         = (col_next_ext >= width);
		even         = ~col_q[0];
	end

	// pair average, truncated
	always_comb begin
		pix   = pixel_in.data;
		sum_r = {1'b0, held_q.red}   + {1'b0, pix.red};
		sum_g = {1'b0, held_q.green} + {1'b0, pix.green};
		sum_b = {1'b0, held_q.blue}  + {1'b0, pix.blue};
	end

	// slot and byte events
	always_comb begin
		if (cfg_state.pixel_mode == MODE_PALETTE) begin
			place    = ~even;
			slot_cur = {1'b0, slot_q[1:0]};
			full     = place && (slot_q[1:0] == 2'd3);
			slot_new = place ? (slot_cur + 3'd1) : slot_q;
		end else begin
			place    = 1'b1;
			slot_cur = slot_q;
			full     = (slot_q == 3'd7);
			slot_new = slot_q + 3'd1;
		end
		emit = full || (last && (slot_new != 3'd0));

		item.mode  = cfg_state.pixel_mode;
		item.pal   = cfg_state.palette_select;
		item.place = place;
		item.emit  = emit;
		item.last  = last;
		item.slot  = slot_cur;
		if (cfg_state.pixel_mode == MODE_PALETTE) begin
			item.pix = '{red: sum_r[8:1], green: sum_g[8:1], blue: sum_b[8:1]};
		end else begin
			item.pix = pix;
		end
	end

	assign item_out.data = item;

	// row state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			slot_q <= '0;
			held_q <= '0;
		end else if (accept) begin
			col_q  <= last ? '0 : (col_q + COLW'(1));
			slot_q <= (emit || last) ? 3'd0 : slot_new;
			if (cfg_state.pixel_mode == MODE_PALETTE && even) begin
				held_q <= pix;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/p2v_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// p2v_queue: item queue
// Small FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module p2v_queue (
	input  logic         clk,
	input  logic         arst_n,
	p2v_stream_if.sink   item_in,
	p2v_stream_if.source item_out
);
	import p2v_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	p2v_item_t     mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;
	logic          push, pop;

	assign item_in.ready  = (count_q != (PW+1)'(QUEUE_DEPTH));
	assign item_out.valid = (count_q != '0);
	assign item_out.data  = mem_q[rd_ptr_q];
	assign push           = item_in.valid && item_in.ready;
	assign pop            = item_out.valid && item_out.ready;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in.data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + PW'(1);
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/p2v_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// p2v_back: quantize and pack
// Stage 1 forms the four squared palette distances and the luma sum;
// stage 2 picks the nearest color or threshold bit, packs it into the
// byte and loads the output register.
// ----------------------------------------------------------------------------
module p2v_back (
	input  logic         clk,
	input  logic         arst_n,
	p2v_stream_if.sink   item_in,
	p2v_stream_if.source vram_out
);
	import p2v_pkg::*;

	// stage 1 registers
	logic              valid_s1;
	logic              mode_s1, place_s1, emit_s1, last_s1;
	logic [2:0]        slot_s1;
	logic [DIST_W-1:0] dist_s1 [4];
	logic [DIST_W-1:0] luma_s1;

	logic              out_valid_q;
	p2v_byte_t         out_q;
	logic [7:0]        acc_q;

	logic              s1_adv, load_s1;
	logic [DIST_W-1:0] dist_a [4];
	logic [DIST_W-1:0] luma_a;
	logic [DIST_W-1:0] best_d;
	logic [1:0]        best_idx;
	logic              luma_bit;
	logic [7:0]        bits, acc_next;
	p2v_item_t         it;

	assign s1_adv        = valid_s1 && (!emit_s1 || !out_valid_q || vram_out.ready);
	assign item_in.ready = !valid_s1 || s1_adv;
	assign load_s1       = item_in.valid && item_in.ready;

	// distances and luma sum for the head item
	always_comb begin
		it = item_in.data;
		for (int i = 0; i < 4; i++) begin
			dist_a[i] = p2v_sqdist(it.pix, PAL_TABLE[it.pal][i][0],
				PAL_TABLE[it.pal][i][1], PAL_TABLE[it.pal][i][2]);
		end
		luma_a = DIST_W'(LUMA_R * it.pix.red) + DIST_W'(LUMA_G * it.pix.green)
			+ DIST_W'(LUMA_B * it.pix.blue);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			mode_s1  <= it.mode;
			place_s1 <= it.place;
			emit_s1  <= it.emit;
			last_s1  <= it.last;
			slot_s1  <= it.slot;
			dist_s1  <= dist_a;
			luma_s1  <= luma_a;
		end
	end

	// nearest color, lowest index wins ties
	always_comb begin
		best_d   = dist_s1[0];
		best_idx = 2'd0;
		for (int i = 1; i < 4; i++) begin
			if (dist_s1[i] < best_d) begin
				best_d   = dist_s1[i];
				best_idx = 2'(i);
			end
		end
		luma_bit = (luma_s1 >= LUMA_THRESH);
		if (mode_s1 == MODE_MONO) begin
			bits = luma_bit ? (8'h80 >> slot_s1) : 8'h00;
		end else begin
			bits = {best_idx, 6'b0} >> {slot_s1[1:0], 1'b0};
		end
		acc_next = acc_q | (place_s1 ? bits : 8'h00);
	end

	// partial byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (s1_adv) begin
			acc_q <= (emit_s1 || last_s1) ? 8'h00 : acc_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (vram_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit_s1) begin
			out_q.vram_byte <= acc_next;
			out_q.row_done  <= last_s1;
		end
	end

	assign vram_out.valid = out_valid_q;
	assign vram_out.data  = out_q;

endmodule
`default_nettype wire

// File: rtl/pixel_to_packed_vram_bytes.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_to_packed_vram_bytes: raster pixel to packed video-memory bytes
// Quantizes RGB pixels to 2-bit palette codes or 1-bit luma and packs them.
// ----------------------------------------------------------------------------
// Takes one RGB pixel per clock unless stalled and emits packed bytes with the
// first pixel in the high bits: palette mode averages each horizontal pair and
// packs four nearest-color codes per byte, mono mode packs eight luma bits per
// byte; a partial byte is flushed zero-padded at row end with row_done set, and
// an unpaired trailing palette pixel is dropped. An accepted pixel passes
// through classification into a four-entry queue, a distance stage, then
// selection and packing into the output register. The pixel input stalls
// only when the queue fills behind a stalled output. Write the
// configuration only while the block is idle; writes are always accepted.
// ----------------------------------------------------------------------------
module pixel_to_packed_vram_bytes #(
	parameter int MAX_ROW_WIDTH = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	p2v_stream_if.sink   pixel_in,
	p2v_stream_if.source vram_out,
	p2v_stream_if.sink   cfg
);
	import p2v_pkg::*;

	p2v_cfg_t    cfg_q;
	p2v_cfg_wr_t wr;

	p2v_stream_if #(.payload_t(p2v_pkg::p2v_item_t)) q_in ();
	p2v_stream_if #(.payload_t(p2v_pkg::p2v_item_t)) q_out ();

	// configuration registers
	assign cfg.ready = 1'b1;
	assign wr        = cfg.data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_mode     <= MODE_PALETTE;
			cfg_q.palette_select <= 1'b0;
			cfg_q.row_width      <= ROW_WIDTH_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (wr.index)
				REG_PIXEL_MODE:     cfg_q.pixel_mode     <= wr.wdata[0];
				REG_PALETTE_SELECT: cfg_q.palette_select <= wr.wdata[0];
				REG_ROW_WIDTH:      cfg_q.row_width      <= wr.wdata;
				default: ;
			endcase
		end
	end

	p2v_front #(.MAX_ROW_WIDTH(MAX_ROW_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_state (cfg_q),
		.pixel_in  (pixel_in),
		.item_out  (q_in)
	);

	p2v_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_in  (q_in),
		.item_out (q_out)
	);

	p2v_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_in  (q_out),
		.vram_out (vram_out)
	);

`ifndef SYNTH
	// palette items only use slots 0 to 3
	assert property (@(posedge clk) disable iff (!arst_n)
		q_out.valid && q_out.data.mode == MODE_PALETTE |-> q_out.data.slot[2] == 1'b0)
		else $error("palette item with slot above 3");

	// a mid-row byte only goes out when the byte is full
	assert property (@(posedge clk) disable iff (!arst_n)
		q_in.valid && q_in.data.emit && !q_in.data.last |->
		q_in.data.place && ((q_in.data.mode == MODE_MONO && q_in.data.slot == 3'd7) ||
		(q_in.data.mode == MODE_PALETTE && q_in.data.slot == 3'd3)))
		else $error("mid-row byte emitted before it is full");

	// an item that places nothing never emits unless it ends the row
	assert property (@(posedge clk) disable iff (!arst_n)
		q_in.valid && !q_in.data.place |-> !q_in.data.emit || q_in.data.last)
		else $error("empty item emitted a byte mid-row");
`endif

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: pixel to packed video-memory byte converter testbench
// Drives RGB pixels and register writes into the converter, predicts every
// packed byte from its own model of the packing state, and checks each byte
// that comes out against the oldest prediction, with random stalls on both
// sides and long output hold-offs.
// ----------------------------------------------------------------------------
module tb_top;
	import p2v_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int RANDOM_ITEMS   = 700;
	localparam int MAX_WIDTH      = 256;
	localparam int HOLD_CYCLES    = 300;
	localparam int HOLD_ITEMS     = 40;

	// predicts packed bytes and checks the ones the block sends
	class vram_byte_scoreboard;
		logic       mode;
		logic       pal_sel;
		logic [8:0] width_reg;
		logic [8:0] column;
		p2v_pixel_t held;
		logic [7:0] acc;
		logic [2:0] slots;
		p2v_byte_t  predicted_bytes[$];
		int         errors;
		int         checked;
		int         pixels;

		function new();
			mode      = MODE_PALETTE;
			pal_sel   = 1'b0;
			width_reg = ROW_WIDTH_RESET;
			column    = '0;
			held      = '0;
			acc       = '0;
			slots     = '0;
			errors    = 0;
			checked   = 0;
			pixels    = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [8:0] value);
			case (idx)
				REG_PIXEL_MODE:     mode = value[0];
				REG_PALETTE_SELECT: pal_sel = value[0];
				REG_ROW_WIDTH:      width_reg = value;
				default: ;
			endcase
		endfunction

		// nearest palette entry by squared distance, lowest index on a tie
		function int closest_code(int r, int g, int b);
			int best, best_d, d, i, dr, dg, db;
			best   = 0;
			best_d = 0;
			for (i = 0; i < 4; i++) begin
				dr = r - int'(PAL_TABLE[pal_sel][i][0]);
				dg = g - int'(PAL_TABLE[pal_sel][i][1]);
				db = b - int'(PAL_TABLE[pal_sel][i][2]);
				d  = dr * dr + dg * dg + db * db;
				if (i == 0 || d < best_d) begin
					best_d = d;
					best   = i;
				end
			end
			return best;
		endfunction

		// advance the packing state by one accepted pixel
		function void note_pixel(p2v_pixel_t p);
			int        eff_width, slot, luma, idx;
			bit        last, full;
			p2v_byte_t b;
			pixels++;
			eff_width = int'(width_reg);
			if (eff_width == 0) eff_width = 1;
			if (eff_width > MAX_WIDTH) eff_width = MAX_WIDTH;
			last = (int'(column) + 1 >= eff_width);
			full = 1'b0;
			if (mode == MODE_PALETTE) begin
				if (!column[0]) begin
					held = p;
				end else begin
					slot = int'(slots) % 4;
					idx  = closest_code((int'(held.red) + int'(p.red)) >> 1,
						(int'(held.green) + int'(p.green)) >> 1,
						(int'(held.blue) + int'(p.blue)) >> 1);
					acc   = acc | 8'(idx << (6 - 2 * slot));
					full  = (slot == 3);
					slots = 3'(slot + 1);
				end
			end else begin
				luma = (299 * int'(p.red) + 587 * int'(p.green) + 114 * int'(p.blue)) / 1000;
				slot = int'(slots);
				if (luma > 127) acc = acc | (8'h80 >> slot);
				full  = (slot == 7);
				slots = 3'(slot + 1);
			end
			// full byte, or row end with a partial byte to flush
			if (full || (last && slots != 0)) begin
				b.vram_byte = acc;
				b.row_done  = last;
				predicted_bytes.push_back(b);
				acc   = '0;
				slots = '0;
			end else if (last) begin
				acc   = '0;
				slots = '0;
			end
			column = last ? 9'd0 : column + 9'd1;
		endfunction

		function void check_byte(p2v_byte_t got);
			p2v_byte_t want;
			if (predicted_bytes.size() == 0) begin
				$error("unexpected byte: vram_byte %02h row_done %0b", got.vram_byte, got.row_done);
				errors++;
				return;
			end
			want = predicted_bytes.pop_front();
			checked++;
			if (got.vram_byte !== want.vram_byte) begin
				$error("vram_byte: expected %02h, actual %02h", want.vram_byte, got.vram_byte);
				errors++;
			end
			if (got.row_done !== want.row_done) begin
				$error("row_done: expected %0b, actual %0b", want.row_done, got.row_done);
				errors++;
			end
		endfunction
	endclass

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	p2v_stream_if #(.payload_t(p2v_pixel_t))  pixel_if ();
	p2v_stream_if #(.payload_t(p2v_byte_t))   vram_if ();
	p2v_stream_if #(.payload_t(p2v_cfg_wr_t)) cfg_if ();

	pixel_to_packed_vram_bytes #(.MAX_ROW_WIDTH(MAX_WIDTH)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixel_in (pixel_if),
		.vram_out (vram_if),
		.cfg      (cfg_if)
	);

	vram_byte_scoreboard vram_sb;
	int send_idle_pct = 15;
	int recv_idle_pct = 85;
	int hold_req      = 0;
	int hold_left     = 0;
	int stall_count   = 0;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// output ready: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			vram_if.ready <= 1'b0;
		end else begin
			vram_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// check every byte request taken from the block
	always @(posedge clk) begin
		if (arst_n && vram_if.valid && vram_if.ready) vram_sb.check_byte(vram_if.data);
	end

	// watchdog: too long with no request moving on any channel
	always @(posedge clk) begin
		if (!arst_n || (pixel_if.valid && pixel_if.ready) || (vram_if.valid && vram_if.ready)
				|| (cfg_if.valid && cfg_if.ready)) begin
			stall_count = 0;
		end else begin
			stall_count++;
			if (stall_count >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// offer one pixel after a random gap and wait for it to be taken
	task automatic send_pixel(input p2v_pixel_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			pixel_if.valid <= 1'b0;
		end
		@(negedge clk);
		pixel_if.valid <= 1'b1;
		pixel_if.data  <= p;
		do @(posedge clk); while (!pixel_if.ready);
		vram_sb.note_pixel(p);
	endtask

	// stop offering pixels, wait for all predicted bytes, let the pipe settle
	task automatic wait_for_bytes();
		@(negedge clk);
		pixel_if.valid <= 1'b0;
		while (vram_sb.predicted_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [8:0] value);
		p2v_cfg_wr_t req;
		req.index = idx;
		req.wdata = value;
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= req;
		do @(posedge clk); while (!cfg_if.ready);
		vram_sb.write_reg(idx, value);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic set_config(input logic mode, input logic pal, input logic [8:0] width);
		write_reg(REG_PIXEL_MODE, {8'd0, mode});
		write_reg(REG_PALETTE_SELECT, {8'd0, pal});
		write_reg(REG_ROW_WIDTH, width);
	endtask

	// mix of full-range noise, saturated channels, near-threshold grays and
	// palette colors with small offsets
	function automatic p2v_pixel_t random_pixel();
		p2v_pixel_t p;
		int         c, k;
		case ($urandom_range(3))
			0: p = 24'($urandom);
			1: begin
				p.red   = $urandom_range(1) ? 8'hFF : 8'h00;
				p.green = $urandom_range(1) ? 8'hFF : 8'h00;
				p.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
			end
			2: begin
				k = $urandom_range(124, 131);
				p.red   = 8'(k);
				p.green = 8'(k);
				p.blue  = 8'(k);
			end
			default: begin
				c = $urandom_range(3);
				k = $urandom_range(1);
				p.red   = PAL_TABLE[k][c][0] ^ 8'($urandom_range(3));
				p.green = PAL_TABLE[k][c][1] ^ 8'($urandom_range(3));
				p.blue  = PAL_TABLE[k][c][2] ^ 8'($urandom_range(3));
			end
		endcase
		return p;
	endfunction

	// row widths: mostly short, with zero, the max and values above it
	function automatic logic [8:0] pick_width();
		case ($urandom_range(9))
			0:       return 9'd0;
			1:       return 9'd1;
			2:       return 9'd2;
			3:       return 9'd3;
			4:       return 9'(8 + $urandom_range(1));
			5:       return 9'd256;
			6:       return 9'(257 + $urandom_range(253));
			7:       return 9'd511;
			default: return 9'($urandom_range(4, 40));
		endcase
	endfunction

	// main sequence
	initial begin
		p2v_pixel_t px;
		int         n, phase_len, sent, phases;
		vram_sb        = new();
		pixel_if.valid = 1'b0;
		pixel_if.data  = '0;
		vram_if.ready  = 1'b0;
		cfg_if.valid   = 1'b0;
		cfg_if.data    = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// palette 0, row of 8: one pair per palette color, codes 0..3
		set_config(MODE_PALETTE, 1'b0, 9'd8);
		for (n = 0; n < 8; n++) begin
			px = {PAL_TABLE[0][n / 2][0], PAL_TABLE[0][n / 2][1], PAL_TABLE[0][n / 2][2]};
			send_pixel(px);
		end
		wait_for_bytes();

		// mono, row of 5: partial byte flush, grays on both sides of threshold
		set_config(MODE_MONO, 1'b0, 9'd5);
		send_pixel(24'hFFFFFF);
		send_pixel(24'h000000);
		send_pixel(24'h7F7F7F);
		send_pixel(24'h808080);
		send_pixel(24'hFF0000);
		wait_for_bytes();

		// palette 1, odd row: trailing pixel has no partner and is dropped
		set_config(MODE_PALETTE, 1'b1, 9'd3);
		send_pixel(24'hFF00FF);
		send_pixel(24'h00FF00);
		send_pixel(24'h123456);
		wait_for_bytes();

		// black pair ties on three colors; then a one-pixel palette row
		set_config(MODE_PALETTE, 1'b0, 9'd2);
		send_pixel(24'h000000);
		send_pixel(24'h000000);
		wait_for_bytes();
		write_reg(REG_ROW_WIDTH, 9'd1);
		send_pixel(24'hFFFFFF);
		wait_for_bytes();

		// random phases; settings change between phases, often mid-row
		sent   = 0;
		phases = 0;
		while (sent < RANDOM_ITEMS) begin
			phases++;
			if (phases == 1 || $urandom_range(1))
				write_reg(REG_PIXEL_MODE, 9'($urandom_range(1)));
			if (phases == 1 || $urandom_range(1))
				write_reg(REG_PALETTE_SELECT, 9'($urandom_range(1)));
			if (phases == 1 || $urandom_range(3) != 0)
				write_reg(REG_ROW_WIDTH, pick_width());
			phase_len = $urandom_range(20, 80);
			for (n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
				if (sent < RANDOM_ITEMS / 3) begin
					send_idle_pct = 15;
					recv_idle_pct = 85;
				end else if (sent < 2 * RANDOM_ITEMS / 3) begin
					send_idle_pct = 85;
					recv_idle_pct = 15;
				end else begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				// long output hold-off while pixels keep coming
				if (sent == 2 * RANDOM_ITEMS / 3 + 10) hold_req = HOLD_CYCLES;
				send_pixel(random_pixel());
				sent++;
			end
			wait_for_bytes();
		end

		// mono rows of 8 under a long output hold-off: the queue backs up
		// until the pixel input stalls
		set_config(MODE_MONO, 1'b0, 9'd8);
		hold_req = HOLD_CYCLES;
		for (n = 0; n < HOLD_ITEMS; n++) send_pixel(random_pixel());
		wait_for_bytes();

		$display("Covered %0d pixels, %0d bytes checked, %0d random setting phases.",
			vram_sb.pixels, vram_sb.checked, phases);
		$display("Both modes and palettes, widths 0 to 511, mid-row changes, stalls both sides.");
		if (vram_sb.errors == 0 && vram_sb.predicted_bytes.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
